### hdl/rdb_pkg.sv
// rdb_pkg: shared types and codes of the rle/delta bgra decoder
// parse phase codes, result kinds and the result record type
// no dependencies
`timescale 1ns / 1ps

package rdb_pkg;

  localparam int PhaseW = 4;
  localparam int CountW = 15;

  localparam logic [PhaseW-1:0] PH_IDLE  = 4'd0;
  localparam logic [PhaseW-1:0] PH_A_HI  = 4'd1;
  localparam logic [PhaseW-1:0] PH_A_VAL = 4'd2;
  localparam logic [PhaseW-1:0] PH_A_LIT = 4'd3;
  localparam logic [PhaseW-1:0] PH_D_LO  = 4'd4;
  localparam logic [PhaseW-1:0] PH_D_HI  = 4'd5;
  localparam logic [PhaseW-1:0] PH_R_B   = 4'd6;
  localparam logic [PhaseW-1:0] PH_R_G   = 4'd7;
  localparam logic [PhaseW-1:0] PH_R_R   = 4'd8;
  localparam logic [PhaseW-1:0] PH_L_B   = 4'd9;
  localparam logic [PhaseW-1:0] PH_L_G   = 4'd10;
  localparam logic [PhaseW-1:0] PH_L_R   = 4'd11;

  localparam logic [1:0] KIND_COLOR = 2'd0;
  localparam logic [1:0] KIND_ALPHA = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  localparam logic [1:0] REC_LIT   = 2'd0;
  localparam logic [1:0] REC_RUN   = 2'd1;
  localparam logic [1:0] REC_DELTA = 2'd2;
  localparam logic [1:0] REC_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [15:0] repeat_res;
  } res_t;

endpackage

### hdl/rdb_if.sv
// rdb_if: valid/ready channels of the decoder
// input beat carries one compressed byte, output beat one result
// no dependencies
`timescale 1ns / 1ps

interface rdb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       segment_end;

  modport source (output valid, output data_byte, output segment_end, input ready);
  modport sink (input valid, input data_byte, input segment_end, output ready);
endinterface

interface rdb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [7:0]  alpha;
  logic [15:0] repeat_res;

  modport source (output valid, output result_kind, output blue, output green,
                  output red, output alpha, output repeat_res, input ready);
  modport sink (input valid, input result_kind, input blue, input green,
                input red, input alpha, input repeat_res, output ready);
endinterface

### hdl/rle_delta_bgra_decoder.sv
// rle_delta_bgra_decoder: top level of the run-length / delta pixel decoder
// input channel of compressed bytes, result channel, one mode register
// depends on rdb_pkg, rdb_if, rdb_parser
//
// usage:
//   in_ch carries one compressed byte per beat with segment_end on the last
//   byte of a segment. out_ch carries results: color pixels and alpha pixels
//   with a repeat count, bad color flag or truncated record.
//   cfg_wr_en/cfg_wr_data write pass_mode (0 alpha, 1 color); a write also
//   returns the parser to idle and clears the last color.
//   a byte is taken every cycle while out_ch does not stall. the parser updates in
//   the cycle the byte is accepted and its result, if any, sits in the output
//   register on the next cycle: throughput one byte per cycle unless stalled.
//   the output register is the only buffer: while its result is stalled by
//   out_ch.ready low, in_ch.ready is low; it rises in the cycle the result
//   is taken.
//   reset (rst_n low, synchronous) clears pass_mode to alpha, the parser to
//   idle and the output register to empty.
`timescale 1ns / 1ps

module rle_delta_bgra_decoder (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  rdb_in_if.sink    in_ch,
  rdb_out_if.source out_ch
);
  import rdb_pkg::*;

  logic beat_acc;
  logic res_vld;
  res_t res;
  logic out_vld_r;
  res_t out_r;

  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign beat_acc    = in_ch.valid && in_ch.ready;

  rdb_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .beat_acc    (beat_acc),
    .data_byte   (in_ch.data_byte),
    .segment_end (in_ch.segment_end),
    .res         (res),
    .res_vld     (res_vld)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (beat_acc) begin
      out_vld_r <= res_vld;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_acc && res_vld) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.result_kind = out_r.result_kind;
  assign out_ch.blue        = out_r.blue;
  assign out_ch.green       = out_r.green;
  assign out_ch.red         = out_r.red;
  assign out_ch.alpha       = out_r.alpha;
  assign out_ch.repeat_res  = out_r.repeat_res;

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    beat_acc && res_vld |=> out_ch.valid)
    else $error("accepted result not presented");

  a_no_result_drops: assert property (@(posedge clk) disable iff (!rst_n)
    beat_acc && !res_vld |=> !out_ch.valid)
    else $error("result presented without a source beat");

  a_error_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.result_kind == KIND_BAD || out_ch.result_kind == KIND_TRUNC)
    |-> out_ch.repeat_res == 16'd0)
    else $error("error result carries a pixel count");

  a_pixel_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.result_kind == KIND_COLOR || out_ch.result_kind == KIND_ALPHA)
    |-> out_ch.repeat_res != 16'd0)
    else $error("pixel result with zero count");

endmodule

### hdl/rdb_parser.sv
// rdb_parser: parse state of the decoder and its one-byte update
// holds pass mode, phase, counters and last color; gives at most one result
// depends on rdb_pkg
`timescale 1ns / 1ps

module rdb_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  input  logic         beat_acc,
  input  logic [7:0]   data_byte,
  input  logic         segment_end,
  output rdb_pkg::res_t res,
  output logic         res_vld
);
  import rdb_pkg::*;

  logic              mode_r;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [CountW-1:0] rem_r, rem_nxt, rem_dec;
  logic [15:0]       part_r, part_nxt;
  logic [7:0]        blue_r, blue_nxt;
  logic [7:0]        green_r, green_nxt;
  logic [7:0]        red_r, red_nxt;
  logic              err_r, err_nxt;
  logic [15:0]       word;

  function automatic logic [7:0] sm_add(input logic [7:0] c, input logic [3:0] mag,
                                        input logic neg);
    logic [7:0] m;
    m = {4'b0, mag};
    return neg ? (c - m) : (c + m);
  endfunction

  assign rem_dec = rem_r - CountW'(1);
  assign word    = {data_byte, part_r[7:0]};

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    part_nxt  = part_r;
    blue_nxt  = blue_r;
    green_nxt = green_r;
    red_nxt   = red_r;
    err_nxt   = err_r;
    res       = '0;
    res_vld   = 1'b0;
    if (!err_r) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (!mode_r) begin
            part_nxt  = {8'h00, data_byte};
            phase_nxt = PH_A_HI;
          end else begin
            unique case (data_byte[7:6])
              REC_BAD: begin
                res.result_kind = KIND_BAD;
                res_vld         = 1'b1;
                err_nxt         = 1'b1;
              end
              REC_DELTA: begin
                rem_nxt = {9'b0, data_byte[5:0]};
                if (data_byte[5:0] != 6'd0) phase_nxt = PH_D_LO;
              end
              REC_RUN: begin
                rem_nxt   = {9'b0, data_byte[5:0]};
                phase_nxt = PH_R_B;
              end
              REC_LIT: begin
                rem_nxt = {7'b0, data_byte};
                if (data_byte != 8'd0) phase_nxt = PH_L_B;
              end
              default: ;
            endcase
          end
        end
        PH_A_HI: begin
          rem_nxt = word[14:0];
          if (word[15]) begin
            phase_nxt = PH_A_VAL;
          end else begin
            phase_nxt = (word[14:0] != 15'd0) ? PH_A_LIT : PH_IDLE;
          end
        end
        PH_A_VAL: begin
          res.result_kind = KIND_ALPHA;
          res.alpha       = ~data_byte;
          res.repeat_res  = {1'b0, rem_r} + 16'd1;
          res_vld         = 1'b1;
          rem_nxt         = '0;
          phase_nxt       = PH_IDLE;
        end
        PH_A_LIT: begin
          res.result_kind = KIND_ALPHA;
          res.alpha       = ~data_byte;
          res.repeat_res  = 16'd1;
          res_vld         = 1'b1;
          rem_nxt         = rem_dec;
          if (rem_dec == '0) phase_nxt = PH_IDLE;
        end
        PH_D_LO: begin
          part_nxt  = {8'h00, data_byte};
          phase_nxt = PH_D_HI;
        end
        PH_D_HI: begin
          if (word[15]) begin
            blue_nxt  = blue_r + {3'b0, word[4:0]};
            green_nxt = green_r + {3'b0, word[9:5]};
            red_nxt   = red_r + {3'b0, word[14:10]};
          end else begin
            blue_nxt  = sm_add(blue_r, word[3:0], word[4]);
            green_nxt = sm_add(green_r, word[8:5], word[9]);
            red_nxt   = sm_add(red_r, word[13:10], word[14]);
          end
          res.result_kind = KIND_COLOR;
          res.blue        = blue_nxt;
          res.green       = green_nxt;
          res.red         = red_nxt;
          res.repeat_res  = 16'd1;
          res_vld         = 1'b1;
          rem_nxt         = rem_dec;
          phase_nxt       = (rem_dec != '0) ? PH_D_LO : PH_IDLE;
        end
        PH_R_B, PH_L_B: begin
          part_nxt  = {8'h00, data_byte};
          phase_nxt = phase_r + PhaseW'(1);
        end
        PH_R_G, PH_L_G: begin
          part_nxt  = {data_byte, part_r[7:0]};
          phase_nxt = phase_r + PhaseW'(1);
        end
        PH_R_R, PH_L_R: begin
          blue_nxt        = part_r[7:0];
          green_nxt       = part_r[15:8];
          red_nxt         = data_byte;
          res.result_kind = KIND_COLOR;
          res.blue        = part_r[7:0];
          res.green       = part_r[15:8];
          res.red         = data_byte;
          res_vld         = 1'b1;
          if (phase_r == PH_R_R) begin
            res.repeat_res = {1'b0, rem_r} + 16'd1;
            rem_nxt        = '0;
            phase_nxt      = PH_IDLE;
          end else begin
            res.repeat_res = 16'd1;
            rem_nxt        = rem_dec;
            phase_nxt      = (rem_dec != '0) ? PH_L_B : PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (segment_end) begin
      // record cut short by the end of the segment
      if (!err_nxt && phase_nxt != PH_IDLE && phase_nxt != PH_A_LIT) begin
        res             = '0;
        res.result_kind = KIND_TRUNC;
        res_vld         = 1'b1;
      end
      phase_nxt = PH_IDLE;
      rem_nxt   = '0;
      part_nxt  = '0;
      blue_nxt  = '0;
      green_nxt = '0;
      red_nxt   = '0;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      mode_r  <= rst_n ? cfg_wr_data : 1'b0;
      phase_r <= PH_IDLE;
      rem_r   <= '0;
      part_r  <= '0;
      blue_r  <= '0;
      green_r <= '0;
      red_r   <= '0;
      err_r   <= 1'b0;
    end else if (beat_acc) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      part_r  <= part_nxt;
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

### tb/tb.sv
// tb: self-checking bench for rle_delta_bgra_decoder, alpha and color passes
// bursty byte driver, stalling result sink, in-bench decoder model with scoreboard
// depends on rdb_pkg, rdb_if and the decoder rtl
`timescale 1ns / 1ps

module tb;
  import rdb_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  rdb_in_if  in_ch ();
  rdb_out_if out_ch ();

  rle_delta_bgra_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  beat_t       beat_q[$];
  logic [7:0]  seg_bytes[$];
  res_t        decoded_q[$];
  int unsigned beats_queued;
  int unsigned phase_target;
  int unsigned err_count;

  // decoder model state
  bit               color_mode;
  logic [PhaseW-1:0] dec_phase;
  logic [CountW-1:0] dec_count;
  logic [15:0]      dec_hold;
  logic [7:0]       cur_blue;
  logic [7:0]       cur_green;
  logic [7:0]       cur_red;
  bit               dec_err;

  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned stall_left;
  bit          stall_on;
  beat_t       drv_beat;
  res_t        mon_got;
  res_t        mon_want;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    err_count++;
    if (err_count <= 100) begin
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got_v, want_v);
    end
  endtask

  task automatic reset_segment();
    dec_phase = PH_IDLE;
    dec_count = '0;
    dec_hold  = '0;
    cur_blue  = '0;
    cur_green = '0;
    cur_red   = '0;
    dec_err   = 1'b0;
  endtask

  task automatic apply_delta_word(input logic [15:0] w);
    if (w[15]) begin
      cur_blue  = cur_blue + {3'b0, w[4:0]};
      cur_green = cur_green + {3'b0, w[9:5]};
      cur_red   = cur_red + {3'b0, w[14:10]};
    end else begin
      cur_blue  = w[4] ? cur_blue - {4'b0, w[3:0]} : cur_blue + {4'b0, w[3:0]};
      cur_green = w[9] ? cur_green - {4'b0, w[8:5]} : cur_green + {4'b0, w[8:5]};
      cur_red   = w[14] ? cur_red - {4'b0, w[13:10]} : cur_red + {4'b0, w[13:10]};
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    res_t        r;
    bit          have;
    logic [15:0] w;
    have = 1'b0;
    r = '0;
    if (dec_err) begin
      if (last) reset_segment();
      return;
    end
    case (dec_phase)
      PH_IDLE: begin
        if (!color_mode) begin
          dec_hold  = {8'h00, b};
          dec_phase = PH_A_HI;
        end else begin
          case (b[7:6])
            REC_BAD: begin
              r.result_kind = KIND_BAD;
              have = 1'b1;
              dec_err = 1'b1;
            end
            REC_DELTA: begin
              dec_count = {9'b0, b[5:0]};
              if (b[5:0] != 0) dec_phase = PH_D_LO;
            end
            REC_RUN: begin
              dec_count = {9'b0, b[5:0]};
              dec_phase = PH_R_B;
            end
            default: begin
              dec_count = {7'b0, b};
              if (b != 0) dec_phase = PH_L_B;
            end
          endcase
        end
      end
      PH_A_HI: begin
        w = {b, dec_hold[7:0]};
        dec_count = w[14:0];
        if (w[15]) dec_phase = PH_A_VAL;
        else dec_phase = (w[14:0] != 0) ? PH_A_LIT : PH_IDLE;
      end
      PH_A_VAL: begin
        r.result_kind = KIND_ALPHA;
        r.alpha = b ^ 8'hFF;
        r.repeat_res = {1'b0, dec_count} + 16'd1;
        have = 1'b1;
        dec_count = '0;
        dec_phase = PH_IDLE;
      end
      PH_A_LIT: begin
        r.result_kind = KIND_ALPHA;
        r.alpha = b ^ 8'hFF;
        r.repeat_res = 16'd1;
        have = 1'b1;
        dec_count = dec_count - 1'b1;
        if (dec_count == 0) dec_phase = PH_IDLE;
      end
      PH_D_LO: begin
        dec_hold  = {8'h00, b};
        dec_phase = PH_D_HI;
      end
      PH_D_HI: begin
        apply_delta_word({b, dec_hold[7:0]});
        r.result_kind = KIND_COLOR;
        r.blue = cur_blue;
        r.green = cur_green;
        r.red = cur_red;
        r.repeat_res = 16'd1;
        have = 1'b1;
        dec_count = dec_count - 1'b1;
        dec_phase = (dec_count != 0) ? PH_D_LO : PH_IDLE;
      end
      PH_R_B, PH_L_B: begin
        dec_hold  = {8'h00, b};
        dec_phase = dec_phase + 4'd1;
      end
      PH_R_G, PH_L_G: begin
        dec_hold[15:8] = b;
        dec_phase = dec_phase + 4'd1;
      end
      PH_R_R, PH_L_R: begin
        cur_blue  = dec_hold[7:0];
        cur_green = dec_hold[15:8];
        cur_red   = b;
        r.result_kind = KIND_COLOR;
        r.blue = cur_blue;
        r.green = cur_green;
        r.red = cur_red;
        have = 1'b1;
        if (dec_phase == PH_R_R) begin
          r.repeat_res = {1'b0, dec_count} + 16'd1;
          dec_count = '0;
          dec_phase = PH_IDLE;
        end else begin
          r.repeat_res = 16'd1;
          dec_count = dec_count - 1'b1;
          dec_phase = (dec_count != 0) ? PH_L_B : PH_IDLE;
        end
      end
      default: dec_phase = PH_IDLE;
    endcase
    if (last) begin
      // truncated record replaces any pixel this byte completed
      if (!dec_err && dec_phase != PH_IDLE && dec_phase != PH_A_LIT) begin
        r = '0;
        r.result_kind = KIND_TRUNC;
        have = 1'b1;
      end
      reset_segment();
    end
    if (have) decoded_q = {decoded_q, r};
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (beat_q.size() > 0) begin
        drv_beat = beat_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= drv_beat.data;
        in_ch.segment_end <= drv_beat.last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (stall_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    end
    if ($urandom_range(0, 199) == 0) stall_on = !stall_on;
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        mon_got = {out_ch.result_kind, out_ch.blue, out_ch.green, out_ch.red,
                   out_ch.alpha, out_ch.repeat_res};
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result kind", mon_got.result_kind, -1);
        end else begin
          mon_want = decoded_q.pop_front();
          if (mon_got.result_kind !== mon_want.result_kind)
            report_mismatch("result_kind", mon_got.result_kind, mon_want.result_kind);
          if (mon_got.blue !== mon_want.blue)
            report_mismatch("blue", mon_got.blue, mon_want.blue);
          if (mon_got.green !== mon_want.green)
            report_mismatch("green", mon_got.green, mon_want.green);
          if (mon_got.red !== mon_want.red)
            report_mismatch("red", mon_got.red, mon_want.red);
          if (mon_got.alpha !== mon_want.alpha)
            report_mismatch("alpha", mon_got.alpha, mon_want.alpha);
          if (mon_got.repeat_res !== mon_want.repeat_res)
            report_mismatch("repeat_res", mon_got.repeat_res, mon_want.repeat_res);
        end
      end
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.segment_end);
    end
  end

  task automatic push_beat(input logic [7:0] b, input logic last);
    beat_t t;
    t.data = b;
    t.last = last;
    beat_q = {beat_q, t};
    beats_queued++;
  endtask

  task automatic wait_drained();
    int unsigned k;
    k = 0;
    while ((beat_q.size() > 0 || in_ch.valid || decoded_q.size() > 0) && k < 20000) begin
      @(negedge clk);
      k++;
    end
    // a trailing byte may produce nothing while the parser still settles
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input bit m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    color_mode = m;
    reset_segment();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int unsigned pick_count(input int unsigned hi);
    return ($urandom_range(0, 15) == 0) ? $urandom_range(0, hi) : $urandom_range(0, 5);
  endfunction

  task automatic gen_alpha_seg();
    int unsigned nrec;
    int unsigned n;
    int unsigned sel;
    logic [15:0] flag;
    bit          stop;
    nrec = $urandom_range(1, 5);
    stop = 1'b0;
    for (int i = 0; i < nrec && !stop; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        flag = {1'b1, 15'($urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 40))};
        seg_bytes = {seg_bytes, flag[7:0]};
        seg_bytes = {seg_bytes, flag[15:8]};
        seg_bytes = {seg_bytes, 8'($urandom)};
      end else begin
        if (sel < 9) begin
          n = $urandom_range(0, 6);
          flag = 16'(n);
        end else begin
          // oversized literal, cut short by the segment end
          flag = {1'b0, 15'($urandom)};
          n = $urandom_range(1, 5);
          stop = 1'b1;
        end
        seg_bytes = {seg_bytes, flag[7:0]};
        seg_bytes = {seg_bytes, flag[15:8]};
        for (int j = 0; j < n; j++) seg_bytes = {seg_bytes, 8'($urandom)};
      end
    end
  endtask

  task automatic gen_color_seg();
    int unsigned nrec;
    int unsigned n;
    int unsigned sel;
    bit          stop;
    nrec = $urandom_range(1, 5);
    stop = 1'b0;
    for (int i = 0; i < nrec && !stop; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 7) begin
        n = pick_count(63);
        seg_bytes = {seg_bytes, 8'h80 | 8'(n)};
        for (int j = 0; j < 2 * n; j++) seg_bytes = {seg_bytes, 8'($urandom)};
      end else if (sel < 12) begin
        seg_bytes = {seg_bytes, 8'h40 | 8'($urandom_range(0, 63))};
        for (int j = 0; j < 3; j++) seg_bytes = {seg_bytes, 8'($urandom)};
      end else if (sel < 18) begin
        n = pick_count(20);
        seg_bytes = {seg_bytes, 8'(n)};
        for (int j = 0; j < 3 * n; j++) seg_bytes = {seg_bytes, 8'($urandom)};
      end else if (sel == 18) begin
        seg_bytes = {seg_bytes, 8'hC0 | 8'($urandom_range(0, 63))};
        n = $urandom_range(0, 4);
        for (int j = 0; j < n; j++) seg_bytes = {seg_bytes, 8'($urandom)};
        stop = 1'b1;
      end else begin
        seg_bytes = {seg_bytes, ($urandom_range(0, 1) ? 8'h80 : 8'h00)};
      end
    end
  endtask

  task automatic commit_segment();
    int unsigned len;
    bit          open;
    len = seg_bytes.size();
    if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
    open = (beats_queued + len >= phase_target) && ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) push_beat(seg_bytes[i], !open && (i == len - 1));
    seg_bytes.delete();
  endtask

  initial begin
    bit mode;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.segment_end = 1'b0;
    out_ch.ready = 1'b0;
    gap_left = 0;
    burst_left = 1;
    stall_left = 0;
    stall_on = 1'b1;
    err_count = 0;
    beats_queued = 0;
    color_mode = 1'b0;
    reset_segment();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // alpha: longest run, literal, empty literal, lone flag, short literal
    write_mode(1'b0);
    push_beat(8'hFF, 0); push_beat(8'hFF, 0); push_beat(8'h00, 0);
    push_beat(8'h01, 0); push_beat(8'h00, 0); push_beat(8'h5A, 0);
    push_beat(8'h00, 0); push_beat(8'h00, 0);
    push_beat(8'h34, 1);
    push_beat(8'h05, 0); push_beat(8'h00, 0); push_beat(8'hAA, 1);
    wait_drained();

    // color: both delta forms, longest run, literal, empty flags, bad flag, cut run
    write_mode(1'b1);
    push_beat(8'h82, 0); push_beat(8'hFF, 0); push_beat(8'hFF, 0);
    push_beat(8'hFF, 0); push_beat(8'h7F, 0);
    push_beat(8'h7F, 0); push_beat(8'h01, 0); push_beat(8'h02, 0); push_beat(8'h03, 0);
    push_beat(8'h01, 0); push_beat(8'hFF, 0); push_beat(8'h00, 0); push_beat(8'h80, 0);
    push_beat(8'h80, 0); push_beat(8'h00, 0);
    push_beat(8'hC5, 0); push_beat(8'h11, 0); push_beat(8'h22, 1);
    push_beat(8'h41, 0); push_beat(8'h10, 1);
    wait_drained();

    mode = 1'b1;
    beats_queued = 0;
    while (beats_queued < 950) begin
      if ($urandom_range(0, 3) != 0) mode = !mode;
      write_mode(mode);
      phase_target = beats_queued + $urandom_range(60, 140);
      while (beats_queued < phase_target) begin
        if ($urandom_range(0, 6) == 0) begin
          for (int j = $urandom_range(1, 12); j > 0; j--) seg_bytes = {seg_bytes, 8'($urandom)};
        end else if (mode) begin
          gen_color_seg();
        end else begin
          gen_alpha_seg();
        end
        commit_segment();
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (decoded_q.size() > 0) report_mismatch("results never seen", 0, decoded_q.size());
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule
